// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the detection box decoder rtl
// no dependencies; every macro samples on aclk and is disabled during aresetn low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define DBD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define DBD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dbd_pkg.sv =====
// shared types and constants of the detection box decoder
// no dependencies; imported by every module of the block
package dbd_pkg;

    // decode queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // stride level codes
    localparam logic [1:0] STRIDE_CODE_8  = 2'd0;
    localparam logic [1:0] STRIDE_CODE_16 = 2'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_SCORE       = 3'd0;
    localparam logic [2:0] CFG_INVERSE_RATIO   = 3'd1;
    localparam logic [2:0] CFG_PAD_LEFT        = 3'd2;
    localparam logic [2:0] CFG_PAD_TOP         = 3'd3;
    localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd4;
    localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd5;
    localparam logic [2:0] CFG_MAX_BOXES       = 3'd6;

    // output saturation bounds, Q13.4
    localparam logic signed [28:0] EDGE_MAX_POS = 29'sd131071;
    localparam logic signed [28:0] EDGE_MIN_NEG = -29'sd131072;

    // one point to decode, handed from the front to the back
    typedef struct packed {
        logic [7:0]  grid_col;
        logic [7:0]  grid_row;
        logic [15:0] dist_left;
        logic [15:0] dist_top;
        logic [15:0] dist_right;
        logic [15:0] dist_bottom;
        logic [1:0]  stride_code;
        logic [15:0] best_score;
        logic [7:0]  class_label;
    } job_t;

    // geometry settings used by the back part
    typedef struct packed {
        logic [23:0] inverse_ratio;
        logic [11:0] pad_left;
        logic [11:0] pad_top;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } geom_cfg_t;

    // queue status seen by both sides
    typedef struct packed {
        logic                empty;
        logic                full;
        logic [QUEUE_AW:0]   level;
    } q_stat_t;

endpackage

// ===== hw/rtl/dbd_queue.sv =====
// short decode queue decoupling the front and back parts
// depends on dbd_pkg for job_t and the queue depth
module dbd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dbd_pkg::job_t push_job,
    input  logic          pop,
    output dbd_pkg::job_t head_job,
    output dbd_pkg::q_stat_t stat
);
    import dbd_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job   = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign stat.level = count_reg;

endmodule

// ===== hw/rtl/dbd_front.sv =====
// front part: running argmax, threshold test and per-level box limit
// depends on dbd_pkg; pushes points to be decoded into dbd_queue
module dbd_front #(
    parameter int MAX_CLASSES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [15:0]   class_score,
    input  logic          class_last,
    input  logic          level_start,
    input  logic [1:0]    stride_code,
    input  logic [7:0]    grid_col,
    input  logic [7:0]    grid_row,
    input  logic [15:0]   dist_left,
    input  logic [15:0]   dist_top,
    input  logic [15:0]   dist_right,
    input  logic [15:0]   dist_bottom,
    input  logic [15:0]   min_score,
    input  logic [15:0]   max_boxes_per_level,
    output logic          push,
    output dbd_pkg::job_t push_job
);
    import dbd_pkg::*;

    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [CW-1:0] CLASS_SAT = CW'(MAX_CLASSES - 1);
    localparam logic [16:0]   EMIT_SAT  = 17'h1FFFF;

    logic [15:0]   best_reg,    best_next;
    logic [7:0]    label_reg,   label_next;
    logic [CW-1:0] cc_reg,      cc_next;
    logic [16:0]   emitted_reg, emitted_next;
    logic          stopped_reg, stopped_next;

    logic [16:0]   emitted_eff;
    logic          stopped_eff;
    logic          emit;

    // argmax, class counter and level limit
    always_comb begin
        emitted_eff  = level_start ? '0 : emitted_reg;
        stopped_eff  = level_start ? 1'b0 : stopped_reg;
        best_next    = best_reg;
        label_next   = label_reg;
        cc_next      = cc_reg;
        emitted_next = emitted_eff;
        stopped_next = stopped_eff;
        emit         = 1'b0;

        if (cc_reg == '0) begin
            best_next  = class_score;
            label_next = '0;
        end else if (class_score > best_reg) begin
            best_next  = class_score;
            label_next = 8'(cc_reg);
        end

        if (!class_last) begin
            if (cc_reg < CLASS_SAT) begin
                cc_next = cc_reg + 1'b1;
            end
        end else begin
            cc_next = '0;
            emit    = !(best_next < min_score) && !stopped_eff;
            if (emit) begin
                if (emitted_eff < EMIT_SAT) begin
                    emitted_next = emitted_eff + 1'b1;
                end
                if (emitted_next > {1'b0, max_boxes_per_level}) begin
                    stopped_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg    <= '0;
            label_reg   <= '0;
            cc_reg      <= '0;
            emitted_reg <= '0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            best_reg    <= best_next;
            label_reg   <= label_next;
            cc_reg      <= cc_next;
            emitted_reg <= emitted_next;
            stopped_reg <= stopped_next;
        end
    end

    // job handed to the queue
    assign push                 = accept && emit;
    assign push_job.grid_col    = grid_col;
    assign push_job.grid_row    = grid_row;
    assign push_job.dist_left   = dist_left;
    assign push_job.dist_top    = dist_top;
    assign push_job.dist_right  = dist_right;
    assign push_job.dist_bottom = dist_bottom;
    assign push_job.stride_code = stride_code;
    assign push_job.best_score  = best_next;
    assign push_job.class_label = label_next;

endmodule

// ===== hw/rtl/dbd_back.sv =====
// back part: edge decode through one shared multiplier and the output register
// depends on dbd_pkg; pops jobs from dbd_queue
module dbd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  dbd_pkg::q_stat_t   q_stat,
    input  dbd_pkg::job_t      head_job,
    input  dbd_pkg::geom_cfg_t geom,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [16:0]        box_left,
    output logic [16:0]        box_top,
    output logic [17:0]        box_right,
    output logic [17:0]        box_bottom,
    output logic [15:0]        best_score,
    output logic [7:0]         class_label,
    output logic [1:0]         level_out
);
    import dbd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    localparam logic [2:0] LAST_STEP  = 3'd5;
    localparam logic [2:0] ISSUE_STEPS = 3'd4;

    state_t      state_reg, state_next;
    logic [2:0]  step_reg;
    job_t        job_reg;

    logic signed [23:0] q8_reg;
    logic               q8_vld_reg;
    logic [1:0]         q8_idx_reg;
    logic signed [48:0] prod_reg;
    logic               prod_vld_reg;
    logic [1:0]         prod_idx_reg;
    logic [17:0]        res_reg [4];

    logic [1:0]         idx;
    logic [7:0]         grid;
    logic [15:0]        dist_sel;
    logic [11:0]        pad;
    logic [15:0]        centre;
    logic signed [17:0] d;
    logic signed [22:0] ds;
    logic signed [23:0] q8;
    logic signed [48:0] rnd;
    logic signed [28:0] edge_val;
    logic signed [28:0] lim;
    logic [17:0]        clamped;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_stat.empty) state_next = ST_RUN;
            ST_RUN:  if (step_reg == LAST_STEP) state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign pop = (state_reg == ST_IDLE) && !q_stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RUN) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head_job;
        end
    end

    // operand select for the edge being issued: left, top, right, bottom
    always_comb begin
        idx  = step_reg[1:0];
        grid = idx[0] ? job_reg.grid_row : job_reg.grid_col;
        pad  = idx[0] ? geom.pad_top : geom.pad_left;
        unique case (idx)
            2'd0:    dist_sel = job_reg.dist_left;
            2'd1:    dist_sel = job_reg.dist_top;
            2'd2:    dist_sel = job_reg.dist_right;
            default: dist_sel = job_reg.dist_bottom;
        endcase
        centre = {grid, 8'h80};
        if (idx[1]) begin
            d = $signed({2'b00, centre}) + $signed({2'b00, dist_sel});
        end else begin
            d = $signed({2'b00, centre}) - $signed({2'b00, dist_sel});
        end
        priority if (job_reg.stride_code == STRIDE_CODE_8) begin
            ds = 23'(d) <<< 3;
        end else if (job_reg.stride_code == STRIDE_CODE_16) begin
            ds = 23'(d) <<< 4;
        end else begin
            ds = 23'(d) <<< 5;
        end
        q8 = 24'(ds) - $signed({4'b0000, pad, 8'h00});
    end

    // stage one: offset in Q.8 pixels; stage two: scale by the inverse ratio
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q8_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            q8_vld_reg   <= (state_reg == ST_RUN) && (step_reg < ISSUE_STEPS);
            prod_vld_reg <= q8_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        q8_reg       <= q8;
        q8_idx_reg   <= idx;
        prod_reg     <= 49'(q8_reg) * $signed({1'b0, geom.inverse_ratio});
        prod_idx_reg <= q8_idx_reg;
    end

    // stage three: round half up to Q.4 and clamp
    always_comb begin
        rnd      = prod_reg + 49'sd524288;
        edge_val = rnd[48:20];
        lim      = $signed({12'd0, (prod_idx_reg[0] ? geom.image_height : geom.image_width),
                            4'h0});
        if (!prod_idx_reg[1]) begin
            priority if (edge_val < 29'sd0) begin
                clamped = '0;
            end else if (edge_val > EDGE_MAX_POS) begin
                clamped = 18'(EDGE_MAX_POS);
            end else begin
                clamped = edge_val[17:0];
            end
        end else begin
            priority if (edge_val > lim) begin
                clamped = lim[17:0];
            end else if (edge_val < EDGE_MIN_NEG) begin
                clamped = 18'(EDGE_MIN_NEG);
            end else begin
                clamped = edge_val[17:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_vld_reg) begin
            res_reg[prod_idx_reg] <= clamped;
        end
    end

    // result held until the transaction completes
    assign out_valid   = (state_reg == ST_OUT);
    assign box_left    = res_reg[0][16:0];
    assign box_top     = res_reg[1][16:0];
    assign box_right   = res_reg[2];
    assign box_bottom  = res_reg[3];
    assign best_score  = job_reg.best_score;
    assign class_label = job_reg.class_label;
    assign level_out   = job_reg.stride_code;

endmodule

// ===== hw/rtl/detection_box_decode.sv =====
// top level of the detection box decoder: ports, settings registers, assertions
// depends on dbd_pkg, dbd_front, dbd_queue, dbd_back and assert_macros.svh
//
// channel  | direction | handshake            | payload
// s_       | in        | s_tvalid / s_tready  | s_tdata, s_tlast, s_tuser
// m_       | out       | m_tvalid / m_tready  | m_tdata, m_tuser
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one class score is taken per cycle while the four-entry decode queue has room
// a kept point passes the back part in order: taken from the queue in the idle state, its
// left, top, right and bottom edges issued one per cycle through the shared 24x25
// multiplier, the q8 and product pipeline registers drained, then the output slot
// reset is synchronous and active low and clears all control state
// a stalled m_ side fills the queue; s_tready falls only when it is full
`include "assert_macros.svh"

module detection_box_decode #(
    parameter int MAX_CLASSES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // class_score[15:0], grid_col[23:16], grid_row[31:24], dist_left[47:32],
    // dist_top[63:48], dist_right[79:64], dist_bottom[95:80]
    input  logic [95:0] s_tdata,
    input  logic        s_tlast,   // class_last
    // level_start[0], stride_code[2:1]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // box_left[16:0], box_top[33:17], box_right[51:34], box_bottom[69:52],
    // best_score[85:70], class_label[93:86], zero[95:94]
    output logic [95:0] m_tdata,
    // level_out[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import dbd_pkg::*;

    logic [15:0] min_score_reg;
    logic [23:0] inverse_ratio_reg;
    logic [11:0] pad_left_reg;
    logic [11:0] pad_top_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [15:0] max_boxes_reg;

    logic        s_accept;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        head_job;
    q_stat_t     q_stat;
    geom_cfg_t   geom;

    logic [16:0] box_left;
    logic [16:0] box_top;
    logic [17:0] box_right;
    logic [17:0] box_bottom;
    logic [15:0] best_score;
    logic [7:0]  class_label;

    // settings registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_score_reg       <= '0;
            inverse_ratio_reg   <= 24'd65536;
            pad_left_reg        <= '0;
            pad_top_reg         <= '0;
            image_width_reg     <= '0;
            image_height_reg    <= '0;
            max_boxes_reg       <= 16'd1000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_SCORE:       min_score_reg       <= cfg_data[15:0];
                CFG_INVERSE_RATIO:   inverse_ratio_reg   <= cfg_data;
                CFG_PAD_LEFT:        pad_left_reg        <= cfg_data[11:0];
                CFG_PAD_TOP:         pad_top_reg         <= cfg_data[11:0];
                CFG_IMAGE_WIDTH:     image_width_reg     <= cfg_data[12:0];
                CFG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data[12:0];
                CFG_MAX_BOXES:       max_boxes_reg       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign geom.inverse_ratio = inverse_ratio_reg;
    assign geom.pad_left      = pad_left_reg;
    assign geom.pad_top       = pad_top_reg;
    assign geom.image_width   = image_width_reg;
    assign geom.image_height  = image_height_reg;

    // input transaction
    assign s_tready = !q_stat.full;
    assign s_accept = s_tvalid && s_tready;

    dbd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .accept              (s_accept),
        .class_score         (s_tdata[15:0]),
        .class_last          (s_tlast),
        .level_start         (s_tuser[0]),
        .stride_code         (s_tuser[2:1]),
        .grid_col            (s_tdata[23:16]),
        .grid_row            (s_tdata[31:24]),
        .dist_left           (s_tdata[47:32]),
        .dist_top            (s_tdata[63:48]),
        .dist_right          (s_tdata[79:64]),
        .dist_bottom         (s_tdata[95:80]),
        .min_score           (min_score_reg),
        .max_boxes_per_level (max_boxes_reg),
        .push                (push),
        .push_job            (push_job)
    );

    dbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    dbd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_stat      (q_stat),
        .head_job    (head_job),
        .geom        (geom),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_right   (box_right),
        .box_bottom  (box_bottom),
        .best_score  (best_score),
        .class_label (class_label),
        .level_out   (m_tuser)
    );

    // output packing
    assign m_tdata = {2'b00, class_label, best_score, box_bottom, box_right, box_top,
                      box_left};

    // queue bookkeeping checks
    `DBD_ASSERT_ALWAYS(a_queue_level, q_stat.level <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue overfilled")
    `DBD_ASSERT_IMPLIES(a_push_room, push, !q_stat.full || pop, "push into full queue")
    `DBD_ASSERT_IMPLIES(a_pop_data, pop, !q_stat.empty && !m_tvalid, "pop without job or while busy")

endmodule
